@@ src/indexed_shift_array_macros.svh @@
// ----------------------------------------------------------------------------
// indexed_shift_array_macros.svh
// Assertion macros shared by the indexed shift array RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_ARRAY_MACROS_SVH
`define INDEXED_SHIFT_ARRAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ISA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ISA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/isa_pkg.sv @@
// ----------------------------------------------------------------------------
// isa_pkg
// Shared sizes, operation and status codes, and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

    // Array geometry
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 5;
    localparam int CNT_W = 5;
    localparam int FN_W  = 3;
    localparam int ST_W  = 2;

    // Operation codes
    typedef enum logic [FN_W-1:0] {
        FN_READ  = 3'd0,
        FN_FRONT = 3'd1,
        FN_BACK  = 3'd2,
        FN_INS   = 3'd3,
        FN_ERASE = 3'd4,
        FN_PUSH  = 3'd5,
        FN_POP   = 3'd6,
        FN_NOP   = 3'd7
    } isa_func_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } isa_status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted input item
        logic exec;   // perform the captured operation, fill result register
    } isa_cmd_t;

endpackage

`default_nettype wire

@@ src/isa_if.sv @@
// ----------------------------------------------------------------------------
// isa_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface isa_in_if;
    logic                   valid;
    logic                   ready;
    logic [isa_pkg::FN_W-1:0]  func;
    logic [isa_pkg::POS_W-1:0] position;
    logic [isa_pkg::WIDTH-1:0] data_in;

    modport source (output valid, input ready, output func, output position, output data_in);
    modport sink   (input valid, output ready, input func, input position, input data_in);
endinterface

interface isa_out_if;
    logic                   valid;
    logic                   ready;
    logic [isa_pkg::WIDTH-1:0] data_out;
    logic [isa_pkg::CNT_W-1:0] count;
    logic                   is_empty;
    logic [isa_pkg::ST_W-1:0]  status;

    modport source (output valid, input ready, output data_out, output count,
                    output is_empty, output status);
    modport sink   (input valid, output ready, input data_out, input count,
                    input is_empty, input status);
endinterface

`default_nettype wire

@@ src/isa_ctrl.sv @@
// ----------------------------------------------------------------------------
// isa_ctrl
// Sequencer: takes one item, runs it through the datapath, owns result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_shift_array_macros.svh"

module isa_ctrl
    import isa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output isa_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } isa_state_t;

    isa_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // Result slot can take a new result when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Execute never overwrites a result that has not been transferred
    `ISA_ASSERT_IMPLY(a_exec_slot_free, cmd.exec, !out_valid_reg || out_ready, "exec over held result")
    // A capture is always followed by its execute step in the next state
    `ISA_ASSERT_NEXT(a_load_then_exec, cmd.load, state_reg == S_EXEC, "load not followed by exec")
    // An execute raises result valid
    `ISA_ASSERT_NEXT(a_exec_sets_valid, cmd.exec, out_valid_reg, "exec did not raise valid")

endmodule

`default_nettype wire

@@ src/isa_datapath.sv @@
// ----------------------------------------------------------------------------
// isa_datapath
// Input capture, per-entry shift array, count register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_shift_array_macros.svh"

module isa_datapath
    import isa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  isa_cmd_t              cmd,
    input  wire logic [FN_W-1:0]  in_func,
    input  wire logic [POS_W-1:0] in_pos,
    input  wire logic [WIDTH-1:0] in_data,
    output logic [WIDTH-1:0]      res_data,
    output logic [CNT_W-1:0]      res_count,
    output logic                  res_empty,
    output logic [ST_W-1:0]       res_status
);

    isa_func_t        func_reg;
    logic [POS_W-1:0] pos_reg;
    logic [WIDTH-1:0] word_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] entries_reg  [DEPTH];
    logic [WIDTH-1:0] entries_next [DEPTH];
    logic [WIDTH-1:0] res_data_reg, res_data_next;
    logic [CNT_W-1:0] res_count_reg;
    logic             res_empty_reg;
    isa_status_t      res_status_reg, st;

    logic             is_full, is_zero;
    logic [CNT_W-1:0] n_m1;
    logic [IDX_W-1:0] rd_idx;
    logic [WIDTH-1:0] rd_word;
    logic             do_ins, do_erase, do_push;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= isa_func_t'(in_func);
            pos_reg  <= in_pos;
            word_reg <= in_data;
        end
    end

    assign is_full = (count_reg == CNT_W'(DEPTH));
    assign is_zero = (count_reg == '0);
    assign n_m1    = count_reg - CNT_W'(1);

    // Select the read address: front, back or the given index
    always_comb
    begin
        case (func_reg)
            FN_FRONT: rd_idx = '0;
            FN_BACK:  rd_idx = n_m1[IDX_W-1:0];
            default:  rd_idx = pos_reg[IDX_W-1:0];
        endcase
    end

    assign rd_word = entries_reg[rd_idx];

    // Decode the operation: status, read word, new count, array update
    always_comb
    begin
        st            = ST_OK;
        res_data_next = '0;
        count_next    = count_reg;
        do_ins        = 1'b0;
        do_erase      = 1'b0;
        do_push       = 1'b0;
        case (func_reg)
            FN_READ:
            begin
                if (pos_reg >= count_reg) st = ST_RANGE;
                else                      res_data_next = rd_word;
            end
            FN_FRONT, FN_BACK:
            begin
                if (is_zero) st = ST_EMPTY;
                else         res_data_next = rd_word;
            end
            FN_INS:
            begin
                if (is_full)                 st = ST_FULL;
                else if (pos_reg > count_reg) st = ST_RANGE;
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_ERASE:
            begin
                if (pos_reg >= count_reg) st = ST_RANGE;
                else
                begin
                    do_erase   = 1'b1;
                    count_next = n_m1;
                end
            end
            FN_PUSH:
            begin
                if (is_full) st = ST_FULL;
                else
                begin
                    do_push    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_POP:
            begin
                if (is_zero) st = ST_EMPTY;
                else         count_next = n_m1;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    // Per-entry next value: each entry looks only at its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        logic [CNT_W-1:0] slot;
        logic [WIDTH-1:0] lower, upper;

        assign slot = CNT_W'(i);

        if (i > 0)
        begin : g_lower
            assign lower = entries_reg[i-1];
        end
        else
        begin : g_lower0
            assign lower = entries_reg[i];
        end

        if (i < DEPTH - 1)
        begin : g_upper
            assign upper = entries_reg[i+1];
        end
        else
        begin : g_upper_last
            assign upper = entries_reg[i];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins && slot == pos_reg)
                entries_next[i] = word_reg;
            else if (do_ins && slot > pos_reg && slot <= count_reg)
                entries_next[i] = lower;
            else if (do_erase && slot >= pos_reg && (slot + CNT_W'(1)) < count_reg)
                entries_next[i] = upper;
            else if (do_push && slot == count_reg)
                entries_next[i] = word_reg;
        end

        // Advance the entry on execute
        always_ff @(posedge clk)
        begin
            if (cmd.exec)
                entries_reg[i] <= entries_next[i];
        end
    end

    // Count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    // Result register, held until the next execute
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_data_reg   <= res_data_next;
            res_count_reg  <= count_next;
            res_empty_reg  <= (count_next == '0);
            res_status_reg <= st;
        end
    end

    assign res_data   = res_data_reg;
    assign res_count  = res_count_reg;
    assign res_empty  = res_empty_reg;
    assign res_status = res_status_reg;

    // Count never exceeds the capacity
    `ISA_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count above capacity")
    // A failed operation leaves the count alone
    `ISA_ASSERT_NEXT(a_fail_keeps_count, cmd.exec && st != ST_OK, $stable(count_reg), "failed op moved count")
    // Count only moves on execute
    `ISA_ASSERT_NEXT(a_idle_keeps_count, !cmd.exec, $stable(count_reg), "count moved without exec")
    // A successful push grows the count by one
    `ISA_ASSERT_NEXT(a_push_grows, cmd.exec && func_reg == FN_PUSH && st == ST_OK, count_reg == $past(count_reg) + CNT_W'(1), "push did not grow count")

endmodule

`default_nettype wire

@@ src/indexed_shift_array.sv @@
// Each item is captured in the idle state; its per-entry shift update and
// result register write run in the execute state, which waits while an
// earlier result is still held. No new item is taken until that step is done.
// A result waiting at the output does not block the next item's capture.
// Reset: rst_n clears the count, the result valid flag and the sequencer
// state; entries stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// indexed_shift_array
// Ordered word array with indexed read, insert, erase, push and pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_shift_array
    import isa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    isa_in_if.sink    in_ch,
    isa_out_if.source out_ch
);

    isa_cmd_t cmd;

    // Sequencer
    isa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // Array, count and result storage
    isa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (in_ch.func),
        .in_pos     (in_ch.position),
        .in_data    (in_ch.data_in),
        .res_data   (out_ch.data_out),
        .res_count  (out_ch.count),
        .res_empty  (out_ch.is_empty),
        .res_status (out_ch.status)
    );

endmodule

`default_nettype wire

@@ bench/indexed_shift_array_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_array_tb
// Drives read, front, back, insert, erase, push, pop and no-op transfers into
// the indexed shift array and predicts every result with a local copy of the
// stored words and count. Each result is checked field by field in arrival
// order. Both channels idle at random, the result side holds off for a long
// stretch once, and the operation side waits twice until all results arrive.
// ----------------------------------------------------------------------------

module indexed_shift_array_tb;

    import isa_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic [WIDTH-1:0] data_out;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        isa_status_t      status;
    } array_result_t;

    logic clk = 1'b0;
    logic rst_n;

    isa_in_if  in_ch();
    isa_out_if out_ch();

    indexed_shift_array dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted array contents and outstanding results
    logic [WIDTH-1:0] model_words [DEPTH];
    int unsigned      model_count;
    array_result_t    expected_results [$];

    int  fail_count;
    int  items_sent;
    int  results_seen;
    int  op_seen [8];
    int  status_seen [4];
    bit  src_idle_on;
    bit  sink_idle_on;
    int  sink_hold_cycles;

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to the predicted array and return its result
    function automatic array_result_t apply_op(input isa_func_t fn,
                                               input logic [POS_W-1:0] pos,
                                               input logic [WIDTH-1:0] word);
        array_result_t r;
        int unsigned   n;
        int unsigned   i;
        r        = '0;
        r.status = ST_OK;
        n        = model_count;
        case (fn)
            FN_READ:
                if (pos >= n) r.status = ST_RANGE;
                else r.data_out = model_words[pos];
            FN_FRONT:
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = model_words[0];
            FN_BACK:
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = model_words[n-1];
            FN_INS:
                if (n >= DEPTH) r.status = ST_FULL;
                else if (pos > n) r.status = ST_RANGE;
                else
                begin
                    for (i = n; i > pos; i--) model_words[i] = model_words[i-1];
                    model_words[pos] = word;
                    model_count      = n + 1;
                end
            FN_ERASE:
                if (pos >= n) r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < n; i++) model_words[i] = model_words[i+1];
                    model_count = n - 1;
                end
            FN_PUSH:
                if (n >= DEPTH) r.status = ST_FULL;
                else
                begin
                    model_words[n] = word;
                    model_count    = n + 1;
                end
            FN_POP:
                if (n == 0) r.status = ST_EMPTY;
                else model_count = n - 1;
            default: ;
        endcase
        r.count    = model_count[CNT_W-1:0];
        r.is_empty = (model_count == 0);
        return r;
    endfunction

    // Offer one operation, hold it until the transfer, then log its result
    task automatic send_op(input isa_func_t fn, input logic [POS_W-1:0] pos,
                           input logic [WIDTH-1:0] word);
        array_result_t r;
        if (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= fn;
        in_ch.position <= pos;
        in_ch.data_in  <= word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        r = apply_op(fn, pos, word);
        expected_results = {expected_results, r};
        items_sent++;
        op_seen[fn]++;
        status_seen[r.status]++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Every operation but push on an empty array
    task automatic test_empty_array();
        send_op(FN_READ, 5'd0, 32'h0);
        send_op(FN_FRONT, 5'd0, 32'h0);
        send_op(FN_BACK, 5'd0, 32'h0);
        send_op(FN_POP, 5'd0, 32'h0);
        send_op(FN_ERASE, 5'd0, 32'h0);
        send_op(FN_INS, 5'd1, 32'h1234_5678);
        send_op(FN_NOP, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Fill through push, front insert, append insert and middle insert
    task automatic test_fill_to_capacity();
        logic [WIDTH-1:0] word;
        int               k;
        for (k = 0; k < DEPTH; k++)
        begin
            case (k)
                0:       word = 32'h0000_0000;
                1:       word = 32'hFFFF_FFFF;
                2:       word = 32'h8000_0000;
                3:       word = 32'h0000_0001;
                4:       word = 32'hAAAA_AAAA;
                5:       word = 32'h5555_5555;
                default: word = $urandom;
            endcase
            case (k % 4)
                0:       send_op(FN_PUSH, 5'($urandom_range(31)), word);
                1:       send_op(FN_INS, 5'd0, word);
                2:       send_op(FN_INS, 5'(model_count), word);
                default: send_op(FN_INS, 5'(model_count / 2), word);
            endcase
        end
        // Full array: full wins over a bad position on insert
        send_op(FN_PUSH, 5'd0, 32'hDEAD_BEEF);
        send_op(FN_INS, 5'd31, 32'hDEAD_BEEF);
        send_op(FN_ERASE, 5'd16, 32'h0);
        send_op(FN_READ, 5'd15, 32'h0);
    endtask

    // Random operations, mostly in range, drifting between growth and shrink
    task automatic test_random_mix(input int n_items);
        isa_func_t        fn;
        logic [POS_W-1:0] pos;
        logic [WIDTH-1:0] word;
        int               roll;
        int               k;
        bit               grow;
        grow = 1'b1;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 48 == 0) grow = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 8) fn = isa_func_t'(3'($urandom_range(7)));
            else if (roll < 23) fn = FN_READ;
            else if (roll < 29) fn = FN_FRONT;
            else if (roll < 35) fn = FN_BACK;
            else if (roll < 55) fn = grow ? FN_PUSH : FN_POP;
            else if (roll < 78) fn = grow ? FN_INS : FN_ERASE;
            else if (roll < 89) fn = grow ? FN_ERASE : FN_INS;
            else fn = grow ? FN_POP : FN_PUSH;

            if ($urandom_range(99) < 12) pos = 5'($urandom_range(31));
            else if (fn == FN_INS) pos = 5'($urandom_range(model_count));
            else if (model_count == 0) pos = '0;
            else pos = 5'($urandom_range(model_count - 1));

            roll = $urandom_range(99);
            if (roll < 5) word = '0;
            else if (roll < 10) word = '1;
            else word = $urandom;

            send_op(fn, pos, word);
        end
    endtask

    // Hold the result side while operations keep coming, so the input stalls
    task automatic test_output_hold();
        src_idle_on      = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        test_random_mix(24);
        src_idle_on      = 1'b1;
    endtask

    // Result side: random stalls, or a counted hold when requested
    initial
    begin : result_sink
        int hold_left;
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles != 0)
            begin
                hold_left        = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ch.ready    <= 1'b0;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
            begin
                out_ch.ready <= !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    initial
    begin : result_check
        array_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no operation outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_out", 64'(want.data_out), 64'(out_ch.data_out));
                    check_field("count", 64'(want.count), 64'(out_ch.count));
                    check_field("is_empty", 64'(want.is_empty), 64'(out_ch.is_empty));
                    check_field("status", 64'(want.status), 64'(out_ch.status));
                end
            end
        end
    end

    // Stop the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin : run_tests
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FN_NOP;
        in_ch.position   = '0;
        in_ch.data_in    = '0;
        model_count      = 0;
        fail_count       = 0;
        items_sent       = 0;
        results_seen     = 0;
        sink_hold_cycles = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        foreach (op_seen[i]) op_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_array();
        test_fill_to_capacity();
        test_random_mix(400);
        test_output_hold();
        wait_drained();
        test_random_mix(20);

        // Long stretch with no idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_mix(250);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_random_mix(400);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d operations, %0d results: read %0d front %0d back %0d insert %0d",
                 items_sent, results_seen, op_seen[FN_READ], op_seen[FN_FRONT],
                 op_seen[FN_BACK], op_seen[FN_INS]);
        $display("  erase %0d push %0d pop %0d no-op %0d; ok %0d full %0d range %0d empty %0d",
                 op_seen[FN_ERASE], op_seen[FN_PUSH], op_seen[FN_POP], op_seen[FN_NOP],
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
                 status_seen[ST_EMPTY]);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ indexed_shift_array.f @@
+incdir+src
src/isa_pkg.sv
src/isa_if.sv
src/isa_ctrl.sv
src/isa_datapath.sv
src/indexed_shift_array.sv
bench/indexed_shift_array_tb.sv
